// ===== design/gffa_pkg.sv =====
// ----------------------------------------------------------------------------
// gffa_pkg: shared types and helpers for the grid rectangle allocator
// Request codes, the occupancy update command and the column check result.
// ----------------------------------------------------------------------------
package gffa_pkg;

  localparam int unsigned COORD_W          = 5;
  localparam int unsigned DEF_GRID_WIDTH   = 14;
  localparam int unsigned DEF_GRID_HEIGHT  = 9;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // update command for the occupancy bitmap
  typedef struct packed {
    logic               set;
    logic               clr;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_op_t;

  // outcome of checking one candidate column
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] y;
  } col_res_t;

  // true when idx lies in [base, base + len)
  function automatic logic span_hit(logic [COORD_W:0]   idx,
                                    logic [COORD_W-1:0] base,
                                    logic [COORD_W-1:0] len);
    logic [COORD_W:0] lo;
    logic [COORD_W:0] hi;
    lo = {1'b0, base};
    hi = {1'b0, base} + {1'b0, len};
    return (idx >= lo) && (idx < hi);
  endfunction

endpackage

// ===== design/gffa_occ.sv =====
// ----------------------------------------------------------------------------
// gffa_occ: occupancy bitmap
// One flop per cell, cleared at reset; sets or clears a rectangle per command.
// ----------------------------------------------------------------------------
module gffa_occ #(
  parameter int unsigned GRID_WIDTH  = gffa_pkg::DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = gffa_pkg::DEF_GRID_HEIGHT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gffa_pkg::rect_op_t                      op_i,
  output logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0]  rows_o
);
  import gffa_pkg::*;

  logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] rows_d, rows_q;

  always_comb begin
    rows_d = rows_q;
    for (int r = 0; r < int'(GRID_HEIGHT); r++) begin
      for (int c = 0; c < int'(GRID_WIDTH); c++) begin
        if (span_hit((COORD_W+1)'(r), op_i.y, op_i.h) &&
            span_hit((COORD_W+1)'(c), op_i.x, op_i.w)) begin
          if (op_i.set) begin
            rows_d[r][c] = 1'b1;
          end else if (op_i.clr) begin
            rows_d[r][c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

  assign rows_o = rows_q;

endmodule

// ===== design/gffa_col_check.sv =====
// ----------------------------------------------------------------------------
// gffa_col_check: candidate column checker
// Tests every row of one column at once and returns the lowest free corner.
// ----------------------------------------------------------------------------
module gffa_col_check #(
  parameter int unsigned GRID_WIDTH  = gffa_pkg::DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = gffa_pkg::DEF_GRID_HEIGHT
) (
  input  logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] rows_i,
  input  logic [gffa_pkg::COORD_W-1:0]           x_i,
  input  logic [gffa_pkg::COORD_W-1:0]           w_i,
  input  logic [gffa_pkg::COORD_W-1:0]           h_i,
  output gffa_pkg::col_res_t                     res_o
);
  import gffa_pkg::*;

  logic [GRID_WIDTH-1:0]  col_mask;
  logic [GRID_HEIGHT-1:0] busy;
  logic [GRID_HEIGHT-1:0] fits;

  always_comb begin
    for (int c = 0; c < int'(GRID_WIDTH); c++) begin
      col_mask[c] = span_hit((COORD_W+1)'(c), x_i, w_i);
    end
    for (int r = 0; r < int'(GRID_HEIGHT); r++) begin
      busy[r] = |(rows_i[r] & col_mask);
    end
  end

  // a corner fits when its window stays on the grid and no row in it is busy
  always_comb begin
    logic [GRID_HEIGHT-1:0] win;
    for (int y = 0; y < int'(GRID_HEIGHT); y++) begin
      for (int r = 0; r < int'(GRID_HEIGHT); r++) begin
        win[r] = span_hit((COORD_W+1)'(r), COORD_W'(y), h_i);
      end
      fits[y] = ((COORD_W+1)'(y) + {1'b0, h_i} <= (COORD_W+1)'(GRID_HEIGHT)) &&
                !(|(busy & win));
    end
  end

  // lowest fitting row wins
  always_comb begin
    res_o = '0;
    for (int y = int'(GRID_HEIGHT) - 1; y >= 0; y--) begin
      if (fits[y]) begin
        res_o.found = 1'b1;
        res_o.y     = COORD_W'(y);
      end
    end
  end

endmodule

// ===== design/grid_first_fit_rect_allocator.sv =====
// ----------------------------------------------------------------------------
// grid_first_fit_rect_allocator: first-fit rectangle allocator on a cell grid
// Keeps an occupancy bitmap, places rectangles column by column, releases them.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. A release finishes as soon
// as the output register is free. An allocation checks one candidate column per
// cycle (all rows of that column in parallel, in the shared column checker),
// stopping at the first fit or at the last column; an oversized rectangle fails
// without a search. The result then sits in the output register until taken; a
// finishing request waits while that register is full.
// The bitmap is cleared by reset and needs no clearing pass.
module grid_first_fit_rect_allocator #(
  parameter int unsigned GRID_WIDTH  = gffa_pkg::DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = gffa_pkg::DEF_GRID_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] item_width, [9:5] item_height, [14:10] release_x, [19:15] release_y
  input  logic [23:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] place_x, [9:5] place_y
  output logic [15:0] m_axis_tdata,
  // [0] granted
  output logic        m_axis_tuser
);
  import gffa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_d, state_q;
  logic               func_q;
  logic [COORD_W-1:0] w_q, h_q, rx_q, ry_q;
  logic [COORD_W-1:0] x_d, x_q;
  logic               out_valid_d, out_valid_q;
  logic               out_granted_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;

  logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] rows;
  col_res_t           col;
  rect_op_t           op;

  logic               accept;
  logic               out_free;
  logic               too_big;
  logic [COORD_W:0]   x_last;
  logic               at_last;
  logic               is_rel;
  logic               finish;
  logic               granted;
  logic [COORD_W-1:0] in_w, in_h;

  assign in_w = (s_axis_tdata[4:0] == '0) ? COORD_W'(1) : s_axis_tdata[4:0];
  assign in_h = (s_axis_tdata[9:5] == '0) ? COORD_W'(1) : s_axis_tdata[9:5];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign is_rel  = (func_q == FUNC_RELEASE);
  assign too_big = ({1'b0, w_q} > (COORD_W+1)'(GRID_WIDTH)) ||
                   ({1'b0, h_q} > (COORD_W+1)'(GRID_HEIGHT));
  assign x_last  = (COORD_W+1)'(GRID_WIDTH) - {1'b0, w_q};
  assign at_last = ({1'b0, x_q} == x_last);

  gffa_col_check #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_col_check (
    .rows_i (rows),
    .x_i    (x_q),
    .w_i    (w_q),
    .h_i    (h_q),
    .res_o  (col)
  );

  assign finish  = (state_q == ST_RUN) && out_free &&
                   (is_rel || too_big || col.found || at_last);
  assign granted = is_rel || (!too_big && col.found);

  always_comb begin
    op     = '0;
    op.set = finish && !is_rel && !too_big && col.found;
    op.clr = finish && is_rel;
    op.x   = is_rel ? rx_q : x_q;
    op.y   = is_rel ? ry_q : col.y;
    op.w   = w_q;
    op.h   = h_q;
  end

  gffa_occ #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_occ (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .rows_o (rows)
  );

  // sequencer: idle until a word arrives, then finish a release or step through columns
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          x_d     = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else if (!is_rel && !too_big && !col.found && !at_last) begin
          x_d = x_q + COORD_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (accept) begin
      func_q <= s_axis_tuser;
      w_q    <= in_w;
      h_q    <= in_h;
      rx_q   <= s_axis_tdata[14:10];
      ry_q   <= s_axis_tdata[19:15];
    end
    if (finish) begin
      out_granted_q <= granted;
      out_x_q       <= (!is_rel && granted) ? x_q : '0;
      out_y_q       <= (!is_rel && granted) ? col.y : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_granted_q;
  assign m_axis_tdata  = {6'b0, out_y_q, out_x_q};

endmodule
